// File: sv/spnv_pkg.sv
// ----------------------------------------------------------------------------
// spnv_pkg
// Shared types, constants and character-class functions for the store path
// name validator.
// ----------------------------------------------------------------------------
package spnv_pkg;

  localparam int HASH_LEN  = 32;
  localparam int NAME_MAX  = 211;
  localparam int COUNT_CAP = HASH_LEN + NAME_MAX + 2;
  localparam int CNT_W     = $clog2(COUNT_CAP + 1);

  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_EQUAL = 8'h3D;

  localparam logic [31:0] DRV_TAIL = 32'h2E647276;

  typedef enum logic [2:0] {
    ST_VALID     = 3'd0,
    ST_SHORT     = 3'd1,
    ST_BAD_HASH  = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_TOO_LONG  = 3'd4,
    ST_DOT_NAME  = 3'd5,
    ST_DOT_COMP  = 3'd6,
    ST_BAD_CHAR  = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    DOTS_NONE = 2'd0,
    DOTS_ONE  = 2'd1,
    DOTS_TWO  = 2'd2
  } dots_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    is_lower = (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    is_upper = (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic hash_ok(input logic [7:0] c);
    hash_ok = (is_digit(c) || is_lower(c)) &&
              (c != CH_E) && (c != CH_O) && (c != CH_U) && (c != CH_T);
  endfunction

  function automatic logic name_ok(input logic [7:0] c);
    name_ok = is_digit(c) || is_lower(c) || is_upper(c) ||
              (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_DOT) ||
              (c == CH_UNDER) || (c == CH_QUEST) || (c == CH_EQUAL);
  endfunction

endpackage

// File: sv/spnv_in_if.sv
// ----------------------------------------------------------------------------
// spnv_in_if
// Byte request channel: one base-name byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface spnv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_byte;

  modport source (output valid, output char_byte, output last_byte, input ready);
  modport sink   (input valid, input char_byte, input last_byte, output ready);
endinterface

// File: sv/spnv_out_if.sv
// ----------------------------------------------------------------------------
// spnv_out_if
// Result request channel: status, first offending byte, name length and
// derivation flag.
// ----------------------------------------------------------------------------
interface spnv_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] bad_char;
  logic [7:0] name_length;
  logic       is_derivation;

  modport source (output valid, output status, output bad_char, output name_length,
                  output is_derivation, input ready);
  modport sink   (input valid, input status, input bad_char, input name_length,
                  input is_derivation, output ready);
endinterface

// File: sv/store_path_name_validator_top.sv
// ----------------------------------------------------------------------------
// store_path_name_validator_top
// Checks a store-path base name byte by byte and reports one result per name.
//
//   channel  | dir | payload                                      | request
//   in_ch    | in  | char_byte, last_byte                         | one byte
//   out_ch   | out | status, bad_char, name_length, is_derivation | one per name
//
// One byte is taken every cycle while in_ch.ready is high; the result of a name is registered and shows
// on out_ch the cycle after its last byte is taken. in_ch.ready falls only
// while a result waits and out_ch.ready is low. rst_n is synchronous, active
// low, and clears the per-name state and the result valid.
// ----------------------------------------------------------------------------
module store_path_name_validator_top (
  input  logic clk,
  input  logic rst_n,
  spnv_in_if.sink    in_ch,
  spnv_out_if.source out_ch
);
  import spnv_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             hash_err_r, hash_err_nxt;
  logic [7:0]       hash_bad_r, hash_bad_nxt;
  logic             name_err_r, name_err_nxt;
  logic [7:0]       name_bad_r, name_bad_nxt;
  dots_t            dots_r, dots_nxt;
  logic             dot_comp_r, dot_comp_nxt;
  logic [31:0]      tail_r, tail_nxt;

  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [7:0]       bad_r, bad_nxt;
  logic [7:0]       len_out_r, len_out_nxt;
  logic             drv_r, drv_nxt;

  logic             accept;
  logic             in_hash, in_name;
  logic [CNT_W-1:0] pos, n, len;
  logic [7:0]       c;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.bad_char      = bad_r;
  assign out_ch.name_length   = len_out_r;
  assign out_ch.is_derivation = drv_r;

  always_comb begin
    c       = in_ch.char_byte;
    pos     = cnt_r;
    n       = pos - CNT_W'(HASH_LEN + 1);
    in_hash = pos < CNT_W'(HASH_LEN);
    in_name = (pos > CNT_W'(HASH_LEN)) && (pos < CNT_W'(COUNT_CAP));

    cnt_nxt      = cnt_r;
    hash_err_nxt = hash_err_r;
    hash_bad_nxt = hash_bad_r;
    name_err_nxt = name_err_r;
    name_bad_nxt = name_bad_r;
    dots_nxt     = dots_r;
    dot_comp_nxt = dot_comp_r;
    tail_nxt     = tail_r;

    if (in_hash && !hash_ok(c) && !hash_err_r) begin
      hash_err_nxt = 1'b1;
      hash_bad_nxt = c;
    end
    if (in_name) begin
      if ((n < CNT_W'(NAME_MAX)) && !name_ok(c) && !name_err_r) begin
        name_err_nxt = 1'b1;
        name_bad_nxt = c;
      end
      if (n == '0) begin
        dots_nxt = (c == CH_DOT) ? DOTS_ONE : DOTS_NONE;
      end else if (n == CNT_W'(1)) begin
        if (dots_r == DOTS_ONE) begin
          if (c == CH_MINUS) dot_comp_nxt = 1'b1;
          dots_nxt = (c == CH_DOT) ? DOTS_TWO : DOTS_NONE;
        end
      end else if (n == CNT_W'(2)) begin
        if ((dots_r == DOTS_TWO) && (c == CH_MINUS)) dot_comp_nxt = 1'b1;
      end
      tail_nxt = {tail_r[23:0], c};
    end
    if (cnt_r < CNT_W'(COUNT_CAP)) cnt_nxt = cnt_r + CNT_W'(1);

    len = (cnt_nxt > CNT_W'(HASH_LEN)) ? cnt_nxt - CNT_W'(HASH_LEN + 1) : '0;
    drv_nxt = (len >= CNT_W'(4)) && (tail_nxt == DRV_TAIL);
    len_out_nxt = (32'(len) > 32'd255) ? 8'hFF : 8'(len);
    bad_nxt = 8'h00;
    if (cnt_nxt < CNT_W'(HASH_LEN + 1)) begin
      status_nxt  = ST_SHORT;
    end else if (hash_err_nxt) begin
      status_nxt = ST_BAD_HASH;
      bad_nxt    = hash_bad_nxt;
    end else if (len == '0) begin
      status_nxt = ST_EMPTY;
    end else if (len > CNT_W'(NAME_MAX)) begin
      status_nxt = ST_TOO_LONG;
    end else if (((len == CNT_W'(1)) && (dots_nxt == DOTS_ONE)) ||
                 ((len == CNT_W'(2)) && (dots_nxt == DOTS_TWO))) begin
      status_nxt = ST_DOT_NAME;
    end else if (dot_comp_nxt) begin
      status_nxt = ST_DOT_COMP;
    end else if (name_err_nxt) begin
      status_nxt = ST_BAD_CHAR;
      bad_nxt    = name_bad_nxt;
    end else begin
      status_nxt = ST_VALID;
    end

    // drop per-name state after the last byte
    if (in_ch.last_byte) begin
      cnt_nxt      = '0;
      hash_err_nxt = 1'b0;
      hash_bad_nxt = 8'h00;
      name_err_nxt = 1'b0;
      name_bad_nxt = 8'h00;
      dots_nxt     = DOTS_NONE;
      dot_comp_nxt = 1'b0;
      tail_nxt     = 32'h0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hash_err_r  <= 1'b0;
      hash_bad_r  <= 8'h00;
      name_err_r  <= 1'b0;
      name_bad_r  <= 8'h00;
      dots_r      <= DOTS_NONE;
      dot_comp_r  <= 1'b0;
      tail_r      <= 32'h0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r      <= cnt_nxt;
        hash_err_r <= hash_err_nxt;
        hash_bad_r <= hash_bad_nxt;
        name_err_r <= name_err_nxt;
        name_bad_r <= name_bad_nxt;
        dots_r     <= dots_nxt;
        dot_comp_r <= dot_comp_nxt;
        tail_r     <= tail_nxt;
      end
      if (accept && in_ch.last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_ch.last_byte) begin
      status_r  <= status_nxt;
      bad_r     <= bad_nxt;
      len_out_r <= len_out_nxt;
      drv_r     <= drv_nxt;
    end
  end

endmodule
